// ----- rtl/core/rtpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtpc_pkg: shared types and constants of the touch point conditioner
// Field widths, register indexes and reset values, sequencer states and the
// helper that unpacks one conversion reading from its two reply bytes.
// ----------------------------------------------------------------------------
package rtpc_pkg;

  // Field widths
  localparam int RAW_W      = 13;  // one conversion reading
  localparam int SUM_W      = 16;  // running sum of readings
  localparam int SCR_W      = 12;  // screen size and plate resistance
  localparam int PX_W       = 14;  // point_x
  localparam int PY_W       = 13;  // point_y
  localparam int PZ_W       = 16;  // point_z
  localparam int AVG_W      = 14;  // averaged readings on the result channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Datapath widths
  localparam int MAP_W      = RAW_W + SCR_W;       // (d - lo) * range
  localparam int PA_W       = 2 * RAW_W;           // (z2 - z1) * x
  localparam int PROD_W     = PA_W + SCR_W;        // (z2 - z1) * x * plate
  localparam int PZ_SHIFT   = 12;                  // divide by 4096
  localparam int DIV_W      = PROD_W - PZ_SHIFT;   // shared dividend width
  localparam int SIMPLE_W   = 15;                  // 1023 - (z2 - z1)

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLATE_RES    = 3'd6;

  // Register reset values
  localparam logic [RAW_W-1:0] RST_X_RAW_MIN = 13'd200;
  localparam logic [RAW_W-1:0] RST_X_RAW_MAX = 13'd3800;
  localparam logic [RAW_W-1:0] RST_Y_RAW_MIN = 13'd200;
  localparam logic [RAW_W-1:0] RST_Y_RAW_MAX = 13'd3700;
  localparam logic [SCR_W-1:0] RST_SCREEN_W  = 12'd240;
  localparam logic [SCR_W-1:0] RST_SCREEN_H  = 12'd320;
  localparam logic [SCR_W-1:0] RST_PLATE_RES = 12'd300;

  // Pressure offset of the simple formula
  localparam logic signed [SIMPLE_W-1:0] SIMPLE_BASE = 15'sd1023;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_GO,
    ST_DIV,
    ST_LOAD
  } rtpc_state_t;

  // Reading is ((hi << 8) | lo) >> 3
  function automatic logic [RAW_W-1:0] reading(input logic [7:0] hi, input logic [7:0] lo);
    return {hi, lo[7:3]};
  endfunction

endpackage

// ----- rtl/core/rtpc_if.sv -----
// ----------------------------------------------------------------------------
// rtpc_if: sample set and point channels
// Valid/ready channels; a beat moves at a rising edge with both high.
// ----------------------------------------------------------------------------
interface rtpc_in_if import rtpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       pen_up;
  logic [7:0] x_high;
  logic [7:0] x_low;
  logic [7:0] y_high;
  logic [7:0] y_low;
  logic [7:0] z1_high;
  logic [7:0] z1_low;
  logic [7:0] z2_high;
  logic [7:0] z2_low;

  modport source (
    output valid, pen_up, x_high, x_low, y_high, y_low,
           z1_high, z1_low, z2_high, z2_low,
    input  ready
  );
  modport sink (
    input  valid, pen_up, x_high, x_low, y_high, y_low,
           z1_high, z1_low, z2_high, z2_low,
    output ready
  );
endinterface

interface rtpc_out_if import rtpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    touched;
  logic signed [PX_W-1:0]  point_x;
  logic signed [PY_W-1:0]  point_y;
  logic        [PZ_W-1:0]  point_z;
  logic signed [AVG_W-1:0] avg_x;
  logic signed [AVG_W-1:0] avg_y;
  logic signed [AVG_W-1:0] avg_z1;
  logic signed [AVG_W-1:0] avg_z2;

  modport source (
    output valid, touched, point_x, point_y, point_z, avg_x, avg_y, avg_z1, avg_z2,
    input  ready
  );
  modport sink (
    input  valid, touched, point_x, point_y, point_z, avg_x, avg_y, avg_z1, avg_z2,
    output ready
  );
endinterface

// ----- rtl/core/resistive_touch_point_conditioner.sv -----
// ----------------------------------------------------------------------------
// resistive_touch_point_conditioner: averaged touch point and pressure
// Sums sample sets from a resistive touch controller, averages each group
// and maps it to a screen point, mirrored in X, with a pressure estimate.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per sample set (pen flag plus the X, Y, Z1, Z2 reply
//            bytes). A pen-down set that does not close a group is absorbed
//            and gives no result.
//   out_ch : one beat per finished group, and one per pen-up set (points and
//            averages all -1, point_z zero, untouched).
//   cfg_*  : write enable, register index and data; write only while idle.
// Sequence:
//   A pen-up set goes straight to the load state. A set that closes a group
//   is averaged in four lock-step bit-serial dividers by SAMPLES, multiplied
//   in the MUL_A and MUL_B states, then divided in three bit-serial dividers
//   for the X map, the Y map and the pressure quotient, and loaded in the
//   load state. in_ch.ready stays low meanwhile, so no new set is taken
//   until the result is loaded into the output register.
// Reset clears the sums, the sample count and the output valid flag and loads
//   the default calibration. A stalled out_ch holds its beat; new sets are
//   still absorbed, and a pending result waits in the load state until the
//   output register frees up.
// ----------------------------------------------------------------------------
module resistive_touch_point_conditioner import rtpc_pkg::*; #(
  parameter int unsigned SAMPLES = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rtpc_in_if.sink               in_ch,
  rtpc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int               CNT_W     = $clog2(SAMPLES + 1);
  localparam logic [CNT_W-1:0] SAMPLES_C = CNT_W'(SAMPLES);
  localparam int               LANES     = 4;  // X, Y, Z1, Z2

  // --------------------------------------------------------------------------
  // Calibration registers
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r;
  logic [SCR_W-1:0] scr_w_r, scr_h_r, plate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= RST_X_RAW_MIN;
      x_max_r <= RST_X_RAW_MAX;
      y_min_r <= RST_Y_RAW_MIN;
      y_max_r <= RST_Y_RAW_MAX;
      scr_w_r <= RST_SCREEN_W;
      scr_h_r <= RST_SCREEN_H;
      plate_r <= RST_PLATE_RES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_RAW_MIN: x_min_r <= cfg_data;
        CFG_X_RAW_MAX: x_max_r <= cfg_data;
        CFG_Y_RAW_MIN: y_min_r <= cfg_data;
        CFG_Y_RAW_MAX: y_max_r <= cfg_data;
        CFG_SCREEN_W:  scr_w_r <= cfg_data[SCR_W-1:0];
        CFG_SCREEN_H:  scr_h_r <= cfg_data[SCR_W-1:0];
        CFG_PLATE_RES: plate_r <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  rtpc_state_t state_r, state_nxt;
  logic        in_ready, accept, group_end;
  logic        avg_start, main_start, out_load, out_free;
  logic [LANES-1:0] avg_done;
  logic [2:0]       main_done;
  logic             out_valid_r;

  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.pen_up) begin
          state_nxt = ST_LOAD;
        end else if (accept && group_end) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        if (&avg_done) state_nxt = ST_MUL_A;
      end
      ST_MUL_A:  state_nxt = ST_MUL_B;
      ST_MUL_B:  state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (&main_done) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready   = rst_n && (state_r == ST_IDLE);
    avg_start  = accept && !in_ch.pen_up && group_end;
    main_start = (state_r == ST_DIV_GO);
    out_load   = (state_r == ST_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ch.ready = in_ready;

  // --------------------------------------------------------------------------
  // Accumulate readings
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0] rd      [LANES];
  logic [SUM_W-1:0] sum_r   [LANES];
  logic [SUM_W-1:0] sum_nxt [LANES];
  logic [CNT_W-1:0] cnt_r, cnt_inc;
  logic             pen_r;

  assign rd[0] = reading(in_ch.x_high,  in_ch.x_low);
  assign rd[1] = reading(in_ch.y_high,  in_ch.y_low);
  assign rd[2] = reading(in_ch.z1_high, in_ch.z1_low);
  assign rd[3] = reading(in_ch.z2_high, in_ch.z2_low);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum_nxt[i] = sum_r[i] + SUM_W'(rd[i]);
    end
    cnt_inc   = cnt_r + CNT_W'(1);
    group_end = (cnt_inc == SAMPLES_C);
  end

  // Drop the group on pen-up, restart it once it closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) sum_r[i] <= '0;
      cnt_r <= '0;
      pen_r <= 1'b0;
    end else if (accept) begin
      pen_r <= in_ch.pen_up;
      if (in_ch.pen_up || group_end) begin
        for (int i = 0; i < LANES; i++) sum_r[i] <= '0;
        cnt_r <= '0;
      end else begin
        for (int i = 0; i < LANES; i++) sum_r[i] <= sum_nxt[i];
        cnt_r <= cnt_inc;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Average: four serial dividers by SAMPLES in lock step
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] avg_q [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_avg
    rtpc_sdiv #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
    ) u_avg_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (avg_start),
      .num   (sum_nxt[g]),
      .den   (SAMPLES_C),
      .quot  (avg_q[g]),
      .done  (avg_done[g])
    );
  end

  // --------------------------------------------------------------------------
  // Multiplies: map numerators, then pressure numerator
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0]        avg_r [LANES];
  logic [MAP_W-1:0]        mx_r, my_r;
  logic [PA_W-1:0]         pa_r;
  logic [PROD_W-1:0]       pn_r;
  logic signed [RAW_W:0]   dz, dz_r;
  logic [RAW_W-1:0]        ax, ay, az1, az2;

  assign ax  = avg_q[0][RAW_W-1:0];
  assign ay  = avg_q[1][RAW_W-1:0];
  assign az1 = avg_q[2][RAW_W-1:0];
  assign az2 = avg_q[3][RAW_W-1:0];
  assign dz  = $signed({1'b0, az2}) - $signed({1'b0, az1});

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_A) begin
      for (int i = 0; i < LANES; i++) avg_r[i] <= avg_q[i][RAW_W-1:0];
      mx_r <= MAP_W'(ax - x_min_r) * MAP_W'(scr_w_r);
      my_r <= MAP_W'(ay - y_min_r) * MAP_W'(scr_h_r);
      dz_r <= dz;
      // Non-positive difference gives a zero pressure numerator
      pa_r <= (dz > 0) ? PA_W'(dz[RAW_W-1:0]) * PA_W'(ax) : '0;
    end
    if (state_r == ST_MUL_B) begin
      pn_r <= PROD_W'(pa_r) * PROD_W'(plate_r);
    end
  end

  // --------------------------------------------------------------------------
  // Quotients: X map, Y map and pressure on three serial dividers
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0] qx, qy, qz;

  rtpc_sdiv #(
    .NUM_W (DIV_W),
    .DEN_W (RAW_W)
  ) u_map_x_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (main_start),
    .num   (DIV_W'(mx_r)),
    .den   (x_max_r - x_min_r),
    .quot  (qx),
    .done  (main_done[0])
  );

  rtpc_sdiv #(
    .NUM_W (DIV_W),
    .DEN_W (RAW_W)
  ) u_map_y_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (main_start),
    .num   (DIV_W'(my_r)),
    .den   (y_max_r - y_min_r),
    .quot  (qy),
    .done  (main_done[1])
  );

  // Dividing by z1 * 4096 equals dropping 12 bits and dividing by z1
  rtpc_sdiv #(
    .NUM_W (DIV_W),
    .DEN_W (RAW_W)
  ) u_press_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (main_start),
    .num   (pn_r[PROD_W-1:PZ_SHIFT]),
    .den   (avg_r[2]),
    .quot  (qz),
    .done  (main_done[2])
  );

  // --------------------------------------------------------------------------
  // Final point: clamp, mirror X and saturate
  // --------------------------------------------------------------------------
  logic signed [PX_W-1:0]     map_x, px;
  logic signed [PY_W-1:0]     py;
  logic        [PZ_W-1:0]     pz;
  logic                       touched;
  logic signed [SIMPLE_W-1:0] simple;

  always_comb begin
    priority if (x_min_r == x_max_r) begin
      map_x = '1;
    end else if (avg_r[0] < x_min_r) begin
      map_x = '0;
    end else if (avg_r[0] > x_max_r) begin
      map_x = PX_W'(scr_w_r);
    end else begin
      map_x = PX_W'(qx[SCR_W-1:0]);
    end
    px = PX_W'(scr_w_r) - map_x;

    priority if (y_min_r == y_max_r) begin
      py = '1;
    end else if (avg_r[1] < y_min_r) begin
      py = '0;
    end else if (avg_r[1] > y_max_r) begin
      py = PY_W'(scr_h_r);
    end else begin
      py = PY_W'(qy[SCR_W-1:0]);
    end

    simple = SIMPLE_BASE - SIMPLE_W'(dz_r);

    priority if (avg_r[2] == '0) begin
      touched = 1'b0;
      pz      = '0;
    end else if (plate_r != '0) begin
      touched = 1'b1;
      pz      = (qz[DIV_W-1:PZ_W] != '0) ? '1 : qz[PZ_W-1:0];
    end else begin
      touched = 1'b1;
      pz      = simple[SIMPLE_W-1] ? '0 : PZ_W'(simple[SIMPLE_W-2:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the beat until the sink takes it
  // --------------------------------------------------------------------------
  logic                    touched_r;
  logic signed [PX_W-1:0]  px_r;
  logic signed [PY_W-1:0]  py_r;
  logic        [PZ_W-1:0]  pz_r;
  logic signed [AVG_W-1:0] out_avg_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (pen_r) begin
        touched_r <= 1'b0;
        px_r      <= '1;
        py_r      <= '1;
        pz_r      <= '0;
        for (int i = 0; i < LANES; i++) out_avg_r[i] <= '1;
      end else begin
        touched_r <= touched;
        px_r      <= px;
        py_r      <= py;
        pz_r      <= pz;
        for (int i = 0; i < LANES; i++) out_avg_r[i] <= AVG_W'(avg_r[i]);
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.touched = touched_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;
  assign out_ch.point_z = pz_r;
  assign out_ch.avg_x   = out_avg_r[0];
  assign out_ch.avg_y   = out_avg_r[1];
  assign out_ch.avg_z1  = out_avg_r[2];
  assign out_ch.avg_z2  = out_avg_r[3];

endmodule

// ----- rtl/core/rtpc_sdiv.sv -----
// ----------------------------------------------------------------------------
// rtpc_sdiv: bit-serial restoring divider
// Shifts the dividend out one bit per cycle and the quotient in behind it;
// once the last step is done, quot holds num / den and stays until restarted.
// ----------------------------------------------------------------------------
module rtpc_sdiv #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    fits    = trial >= {1'b0, den};
    rem_nxt = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(NUM_W);
    end else if (run_r) begin
      cnt_r <= cnt_nxt;
      if (cnt_r == CNT_W'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Last step is in progress this cycle; quot is final from the next one
  assign done = run_r && (cnt_r == CNT_W'(1));
  assign quot = quo_r;

endmodule

// ----- rtl/core/rtpc_chk.sv -----
// ----------------------------------------------------------------------------
// rtpc_chk: port-level checks of the touch point conditioner
// Watches the channel ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module rtpc_chk import rtpc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_pen_up,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_touched,
  input logic signed [PX_W-1:0]  out_point_x,
  input logic        [PZ_W-1:0]  out_point_z,
  input logic signed [AVG_W-1:0] out_avg_x,
  input logic signed [AVG_W-1:0] out_avg_z1
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present right after reset");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) && $stable(out_point_z))
    else $error("stalled result beat changed or vanished");

  // A pen-up beat taken with the output free shows an untouched point once it passes the load state
  a_pen_up_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_pen_up && !out_valid
      |=> ##1 out_valid && !out_touched && out_avg_x == '1 && out_point_x == '1)
    else $error("pen-up beat did not give an untouched point");

  // A touched point needs a nonzero averaged Z1
  a_touch_z1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_touched |-> out_avg_z1 != '0 && !out_avg_z1[AVG_W-1])
    else $error("touched point with zero or missing Z1 average");

endmodule

bind resistive_touch_point_conditioner rtpc_chk u_rtpc_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_pen_up   (in_ch.pen_up),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_touched (out_ch.touched),
  .out_point_x (out_ch.point_x),
  .out_point_z (out_ch.point_z),
  .out_avg_x   (out_ch.avg_x),
  .out_avg_z1  (out_ch.avg_z1)
);
